@@ design/ps2s1_pkg.sv @@
// Package for the scancode set 1 decoder: scan codes, key numbers, modifier
// masks, the event struct and the two ASCII tables.
// No dependencies.
package ps2s1_pkg;

  // raw byte and base codes (low seven bits)
  localparam logic [7:0] SC_PREFIX   = 8'hE0;
  localparam logic [6:0] BC_CTRL     = 7'h1D;
  localparam logic [6:0] BC_ALT      = 7'h38;
  localparam logic [6:0] BC_META_L   = 7'h5B;
  localparam logic [6:0] BC_META_R   = 7'h5C;
  localparam logic [6:0] BC_SHIFT_L  = 7'h2A;
  localparam logic [6:0] BC_SHIFT_R  = 7'h36;
  localparam logic [6:0] BC_F1       = 7'h3B;
  localparam logic [6:0] BC_F10      = 7'h44;
  localparam logic [6:0] BC_F11      = 7'h57;
  localparam logic [6:0] BC_F12      = 7'h58;
  localparam logic [6:0] BC_TAB_END  = 7'h40;

  localparam logic [6:0] BC_UP       = 7'h48;
  localparam logic [6:0] BC_DOWN     = 7'h50;
  localparam logic [6:0] BC_LEFT     = 7'h4B;
  localparam logic [6:0] BC_RIGHT    = 7'h4D;
  localparam logic [6:0] BC_HOME     = 7'h47;
  localparam logic [6:0] BC_END      = 7'h4F;
  localparam logic [6:0] BC_PGUP     = 7'h49;
  localparam logic [6:0] BC_PGDN     = 7'h51;
  localparam logic [6:0] BC_INSERT   = 7'h52;
  localparam logic [6:0] BC_DELETE   = 7'h53;

  // key numbers
  localparam logic [4:0] KID_SHIFT  = 5'd0;
  localparam logic [4:0] KID_CTRL   = 5'd1;
  localparam logic [4:0] KID_ALT    = 5'd2;
  localparam logic [4:0] KID_META   = 5'd3;
  localparam logic [4:0] KID_UP     = 5'd4;
  localparam logic [4:0] KID_DOWN   = 5'd5;
  localparam logic [4:0] KID_LEFT   = 5'd6;
  localparam logic [4:0] KID_RIGHT  = 5'd7;
  localparam logic [4:0] KID_HOME   = 5'd8;
  localparam logic [4:0] KID_END    = 5'd9;
  localparam logic [4:0] KID_PGUP   = 5'd10;
  localparam logic [4:0] KID_PGDN   = 5'd11;
  localparam logic [4:0] KID_INSERT = 5'd12;
  localparam logic [4:0] KID_DELETE = 5'd13;
  localparam logic [4:0] KID_F1     = 5'd14;
  localparam logic [4:0] KID_F11    = 5'd24;
  localparam logic [4:0] KID_F12    = 5'd25;

  // modifier mask bits
  localparam logic [7:0] M_SHIFT   = 8'h01;
  localparam logic [7:0] M_SHIFT_R = 8'h02;
  localparam logic [7:0] M_CTRL    = 8'h04;
  localparam logic [7:0] M_CTRL_R  = 8'h08;
  localparam logic [7:0] M_ALT     = 8'h10;
  localparam logic [7:0] M_ALT_R   = 8'h20;
  localparam logic [7:0] M_META    = 8'h40;
  localparam logic [7:0] M_META_R  = 8'h80;
  localparam logic [7:0] M_NO_TEXT = M_CTRL | M_ALT | M_META;

  // output tdata layout
  localparam int TD_KEY_LO  = 0;
  localparam int TD_CHAR_LO = 5;
  localparam int TD_PRESSED = 12;
  localparam int TD_MASK_LO = 13;
  localparam int TD_TEXT    = 21;

  typedef struct packed {
    logic       named;
    logic [4:0] key_id;
    logic [6:0] char_code;
    logic       pressed;
    logic [7:0] mask;
    logic       text;
  } evt_t;

  localparam logic [6:0] TAB_PLAIN [64] = '{
    7'd0,   7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
    7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
    7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
    7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,   7'd97,  7'd115,
    7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
    7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
    7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
  };

  localparam logic [6:0] TAB_SHIFT [64] = '{
    7'd0,   7'd27,  7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
    7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,
    7'd81,  7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
    7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,   7'd65,  7'd83,
    7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
    7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,
    7'd66,  7'd78,  7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
  };

  // {hit, key number} for an extended navigation code
  function automatic logic [5:0] nav_lookup(logic [6:0] base);
    logic [5:0] r;
    unique case (base)
      BC_UP:     r = {1'b1, KID_UP};
      BC_DOWN:   r = {1'b1, KID_DOWN};
      BC_LEFT:   r = {1'b1, KID_LEFT};
      BC_RIGHT:  r = {1'b1, KID_RIGHT};
      BC_HOME:   r = {1'b1, KID_HOME};
      BC_END:    r = {1'b1, KID_END};
      BC_PGUP:   r = {1'b1, KID_PGUP};
      BC_PGDN:   r = {1'b1, KID_PGDN};
      BC_INSERT: r = {1'b1, KID_INSERT};
      BC_DELETE: r = {1'b1, KID_DELETE};
      default:   r = {1'b0, KID_SHIFT};
    endcase
    return r;
  endfunction

endpackage

@@ design/ps2_scancode_set1_decoder_unit.sv @@
// Top level of the PS/2 scancode set 1 decoder: input register, prefix and
// modifier state, decode and result register. Depends on ps2s1_pkg,
// ps2s1_decode and ps2s1_out_stage.
//
// Takes one raw set 1 byte per request and gives at most one key event. The
// throughput is one byte per clock while the input side is not stalled, set by
// the combinational table decode between the input register and the result
// register. Backpressure on the result side stalls the input side only once
// both registers are full. The 0xE0 prefix, unknown extended codes and
// unmapped codes give no result. The modifier mask in each event is the mask
// after that event.
module ps2_scancode_set1_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] key_id, [11:5] char_code, [12] pressed,
                                  // [20:13] modifier_mask, [21] goes_to_text, zero pad
  output logic        out_tuser   // [0] is_named_key
);
  import ps2s1_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       prefix_r;
  logic [7:0] mods_r;
  logic       prefix_nxt;
  logic [7:0] mods_nxt;
  logic       evt_vld;
  evt_t       evt;
  evt_t       evt_q;
  logic       space;
  logic       advance;

  assign advance   = in_vld_r & space;
  assign in_tready = ~in_vld_r | space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      prefix_r <= 1'b0;
      mods_r   <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        prefix_r <= prefix_nxt;
        mods_r   <= mods_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  ps2s1_decode u_decode (
    .scan_byte  (in_byte_r),
    .prefix     (prefix_r),
    .mods       (mods_r),
    .prefix_nxt (prefix_nxt),
    .mods_nxt   (mods_nxt),
    .evt_vld    (evt_vld),
    .evt        (evt)
  );

  ps2s1_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance & evt_vld),
    .evt        (evt),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .evt_q      (evt_q)
  );

  always_comb begin
    out_tdata                          = '0;
    out_tdata[TD_KEY_LO +: 5]          = evt_q.key_id;
    out_tdata[TD_CHAR_LO +: 7]         = evt_q.char_code;
    out_tdata[TD_PRESSED]              = evt_q.pressed;
    out_tdata[TD_MASK_LO +: 8]         = evt_q.mask;
    out_tdata[TD_TEXT]                 = evt_q.text;
  end

  assign out_tuser = evt_q.named;

endmodule

@@ design/ps2s1_decode.sv @@
// Single-pass decode of one scancode byte against the prefix flag and the
// modifier mask. Depends on ps2s1_pkg.
module ps2s1_decode (
  input  logic             [7:0] scan_byte,
  input  logic                   prefix,
  input  logic             [7:0] mods,
  output logic                   prefix_nxt,
  output logic             [7:0] mods_nxt,
  output logic                   evt_vld,
  output ps2s1_pkg::evt_t        evt
);
  import ps2s1_pkg::*;

  logic [6:0] base;
  logic       down;
  logic       mod_hit;
  logic [7:0] mod_sel;
  logic [5:0] nav;
  logic [6:0] ch;

  assign base = scan_byte[6:0];
  assign down = ~scan_byte[7];
  assign nav  = nav_lookup(base);
  assign ch   = mods[0] ? TAB_SHIFT[base[5:0]] : TAB_PLAIN[base[5:0]];

  always_comb begin
    prefix_nxt    = 1'b0;
    mod_hit       = 1'b0;
    mod_sel       = '0;
    evt_vld       = 1'b0;
    evt           = '0;
    evt.pressed   = down;
    evt.named     = 1'b1;
    if (scan_byte == SC_PREFIX) begin
      // a repeated prefix just stays pending
      prefix_nxt = 1'b1;
    end else if (prefix) begin
      unique case (base)
        BC_CTRL: begin
          mod_hit = 1'b1; mod_sel = M_CTRL_R | M_CTRL; evt.key_id = KID_CTRL;
        end
        BC_ALT: begin
          mod_hit = 1'b1; mod_sel = M_ALT_R | M_ALT; evt.key_id = KID_ALT;
        end
        BC_META_L: begin
          mod_hit = 1'b1; mod_sel = M_META; evt.key_id = KID_META;
        end
        BC_META_R: begin
          mod_hit = 1'b1; mod_sel = M_META_R | M_META; evt.key_id = KID_META;
        end
        default: begin
          evt_vld    = nav[5];
          evt.key_id = nav[4:0];
        end
      endcase
    end else begin
      priority if (base == BC_SHIFT_L) begin
        mod_hit = 1'b1; mod_sel = M_SHIFT; evt.key_id = KID_SHIFT;
      end else if (base == BC_SHIFT_R) begin
        mod_hit = 1'b1; mod_sel = M_SHIFT_R | M_SHIFT; evt.key_id = KID_SHIFT;
      end else if (base == BC_CTRL) begin
        mod_hit = 1'b1; mod_sel = M_CTRL; evt.key_id = KID_CTRL;
      end else if (base == BC_ALT) begin
        mod_hit = 1'b1; mod_sel = M_ALT; evt.key_id = KID_ALT;
      end else if (base >= BC_F1 && base <= BC_F10) begin
        evt_vld    = 1'b1;
        evt.key_id = KID_F1 + 5'(base - BC_F1);
      end else if (base == BC_F11) begin
        evt_vld    = 1'b1;
        evt.key_id = KID_F11;
      end else if (base == BC_F12) begin
        evt_vld    = 1'b1;
        evt.key_id = KID_F12;
      end else if (base >= BC_TAB_END) begin
        evt_vld = 1'b0;
      end else begin
        // printable; modifiers are untouched on this path
        evt_vld       = (ch != 7'd0);
        evt.named     = 1'b0;
        evt.char_code = ch;
        evt.text      = down && ((mods & M_NO_TEXT) == 8'h00);
      end
    end
    if (mod_hit) begin
      evt_vld = 1'b1;
    end
    mods_nxt = mods;
    if (mod_hit) begin
      mods_nxt = down ? (mods | mod_sel) : (mods & ~mod_sel);
    end
    evt.mask = mods_nxt;
  end

endmodule

@@ design/ps2s1_out_stage.sv @@
// Result register of the decoder: holds one key event until the downstream side
// takes it. Depends on ps2s1_pkg.
module ps2s1_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  ps2s1_pkg::evt_t        evt,
  output logic                   space,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output ps2s1_pkg::evt_t        evt_q
);
  import ps2s1_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  evt_t  evt_r;

  assign space      = ~vld_r | out_tready;
  assign out_tvalid = vld_r;
  assign evt_q      = evt_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evt_r <= evt;
    end
  end

endmodule

@@ design/ps2s1_checker.sv @@
// Port-level checks for the scancode set 1 decoder, bound to the top level.
// Depends on ps2_scancode_set1_decoder_unit's port list only.
module ps2s1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // named keys carry no character and never go to text
  a_named: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[11:5] == 7'd0 && !out_tdata[21]
                                && out_tdata[4:0] <= 5'd25)
    else $error("named key with character payload");

  // printable keys: key number zero, nonzero character, no padding bits
  a_print: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[4:0] == 5'd0 && out_tdata[11:5] != 7'd0
                                 && out_tdata[23:22] == 2'b00)
    else $error("bad printable event");

  // text only for a make with ctrl, alt and meta clear
  a_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[12] && !out_tdata[15] && !out_tdata[17]
                                    && !out_tdata[19])
    else $error("text flag with modifier held or on release");

endmodule

bind ps2_scancode_set1_decoder_unit ps2s1_checker u_ps2s1_checker (.*);

@@ bench/tb_ps2_scancode_set1_decoder_unit.sv @@
// Self-checking bench for the PS/2 set 1 decoder: directed scan codes, then
// random key sequences, each result compared with the row's expected event or a local decode of the byte.
// Depends on ps2s1_pkg and ps2_scancode_set1_decoder_unit.
module tb_ps2_scancode_set1_decoder_unit;
  import ps2s1_pkg::*;

  localparam int NUM_RANDOM   = 500;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 35;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic       named;
    logic [4:0] key_id;
    logic [6:0] char_code;
    logic       pressed;
    logic [7:0] mask;
    logic       text;
  } key_evt_t;

  typedef struct packed {
    logic [7:0] scan;
    logic       typed;   // expected result written in the row
    logic       hit;
    key_evt_t   ev;
  } scan_row_t;

  localparam key_evt_t NO_EVT = '0;

  localparam logic [6:0] PLAIN_CHARS [64] = '{
    7'd0,   7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,
    7'd55,  7'd56,  7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,
    7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
    7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,   7'd97,  7'd115,
    7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
    7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118,
    7'd98,  7'd110, 7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
  };

  localparam logic [6:0] SHIFTED_CHARS [64] = '{
    7'd0,   7'd27,  7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,
    7'd38,  7'd42,  7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,
    7'd81,  7'd87,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,  7'd73,
    7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,   7'd65,  7'd83,
    7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
    7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,
    7'd66,  7'd78,  7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,
    7'd0,   7'd32,  7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0
  };

  localparam logic [6:0] NAV_CODES [10] = '{
    BC_UP, BC_DOWN, BC_LEFT, BC_RIGHT, BC_HOME,
    BC_END, BC_PGUP, BC_PGDN, BC_INSERT, BC_DELETE
  };

  localparam logic [6:0] PLAIN_MOD_CODES [4] = '{BC_SHIFT_L, BC_SHIFT_R, BC_CTRL, BC_ALT};
  localparam logic [6:0] EXT_MOD_CODES [4]   = '{BC_CTRL, BC_ALT, BC_META_L, BC_META_R};

  localparam int NUM_ROWS = 26;
  localparam scan_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{8'h00, 1'b1, 1'b0, NO_EVT},                                       // empty table slot
    '{8'h1E, 1'b1, 1'b1, '{1'b0, KID_SHIFT, 7'd97, 1'b1, 8'h00, 1'b1}},
    '{8'h9E, 1'b1, 1'b1, '{1'b0, KID_SHIFT, 7'd97, 1'b0, 8'h00, 1'b0}},
    '{8'hFF, 1'b1, 1'b0, NO_EVT},                                       // unmapped break
    '{SC_PREFIX, 1'b1, 1'b0, NO_EVT},
    '{SC_PREFIX, 1'b1, 1'b0, NO_EVT},                                   // prefix twice
    '{8'h48, 1'b1, 1'b1, '{1'b1, KID_UP, 7'd0, 1'b1, 8'h00, 1'b0}},
    '{SC_PREFIX, 1'b1, 1'b0, NO_EVT},
    '{8'h2E, 1'b1, 1'b0, NO_EVT},                                       // unknown extended
    '{8'h2A, 1'b1, 1'b1, '{1'b1, KID_SHIFT, 7'd0, 1'b1, 8'h01, 1'b0}},
    '{8'h36, 1'b1, 1'b1, '{1'b1, KID_SHIFT, 7'd0, 1'b1, 8'h03, 1'b0}},
    '{8'h02, 1'b0, 1'b0, NO_EVT},
    '{8'hAA, 1'b0, 1'b0, NO_EVT},                                       // left shift up
    '{8'h02, 1'b0, 1'b0, NO_EVT},
    '{8'hB6, 1'b0, 1'b0, NO_EVT},
    '{SC_PREFIX, 1'b1, 1'b0, NO_EVT},
    '{8'h1D, 1'b0, 1'b0, NO_EVT},
    '{8'h10, 1'b0, 1'b0, NO_EVT},
    '{SC_PREFIX, 1'b1, 1'b0, NO_EVT},
    '{8'hDB, 1'b0, 1'b0, NO_EVT},
    '{SC_PREFIX, 1'b1, 1'b0, NO_EVT},
    '{8'h5C, 1'b0, 1'b0, NO_EVT},
    '{8'h3B, 1'b0, 1'b0, NO_EVT},
    '{8'hD8, 1'b0, 1'b0, NO_EVT},
    '{8'h01, 1'b0, 1'b0, NO_EVT},
    '{8'h0E, 1'b0, 1'b0, NO_EVT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  // travels with in_tdata so the scoreboard sees the row that was accepted
  logic        row_typed = 1'b0;
  logic        row_hit = 1'b0;
  key_evt_t    row_ev = '0;

  logic        idle_en = 1'b1;
  logic        ext_pending;
  logic [7:0]  held_mods;
  key_evt_t    pending_events [$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  int          bytes_sent = 0;

  ps2_scancode_set1_decoder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one byte against the local prefix and modifier state; returns 1
  // when the byte produces a key event.
  function automatic logic decode_scan(input logic [7:0] b, output key_evt_t ev);
    logic [6:0] base;
    logic       make;
    logic       ext;
    logic       hit;
    logic [7:0] bits;
    logic [6:0] ch;
    ev = '0;
    if (b == SC_PREFIX) begin
      ext_pending = 1'b1;
      return 1'b0;
    end
    make = ~b[7];
    base = b[6:0];
    ext = ext_pending;
    ext_pending = 1'b0;
    hit = 1'b1;
    bits = 8'h00;
    ev.named = 1'b1;
    ev.pressed = make;
    if (ext) begin
      case (base)
        BC_CTRL:   begin bits = M_CTRL_R | M_CTRL; ev.key_id = KID_CTRL; end
        BC_ALT:    begin bits = M_ALT_R | M_ALT;   ev.key_id = KID_ALT;  end
        BC_META_L: begin bits = M_META;            ev.key_id = KID_META; end
        BC_META_R: begin bits = M_META_R | M_META; ev.key_id = KID_META; end
        BC_UP:     ev.key_id = KID_UP;
        BC_DOWN:   ev.key_id = KID_DOWN;
        BC_LEFT:   ev.key_id = KID_LEFT;
        BC_RIGHT:  ev.key_id = KID_RIGHT;
        BC_HOME:   ev.key_id = KID_HOME;
        BC_END:    ev.key_id = KID_END;
        BC_PGUP:   ev.key_id = KID_PGUP;
        BC_PGDN:   ev.key_id = KID_PGDN;
        BC_INSERT: ev.key_id = KID_INSERT;
        BC_DELETE: ev.key_id = KID_DELETE;
        default:   hit = 1'b0;
      endcase
    end else begin
      case (base)
        BC_SHIFT_L: begin bits = M_SHIFT;             ev.key_id = KID_SHIFT; end
        BC_SHIFT_R: begin bits = M_SHIFT_R | M_SHIFT; ev.key_id = KID_SHIFT; end
        BC_CTRL:    begin bits = M_CTRL;              ev.key_id = KID_CTRL;  end
        BC_ALT:     begin bits = M_ALT;               ev.key_id = KID_ALT;   end
        default: begin
          if (base >= BC_F1 && base <= BC_F10) begin
            ev.key_id = KID_F1 + 5'(base - BC_F1);
          end else if (base == BC_F11) begin
            ev.key_id = KID_F11;
          end else if (base == BC_F12) begin
            ev.key_id = KID_F12;
          end else if (base >= BC_TAB_END) begin
            hit = 1'b0;
          end else begin
            ch = ((held_mods & M_SHIFT) != 8'h00) ? SHIFTED_CHARS[base[5:0]]
                                                   : PLAIN_CHARS[base[5:0]];
            if (ch == 7'd0) begin
              hit = 1'b0;
            end else begin
              ev.named = 1'b0;
              ev.char_code = ch;
              ev.text = make && ((held_mods & M_NO_TEXT) == 8'h00);
            end
          end
        end
      endcase
    end
    if (!hit) begin
      ev = '0;
      return 1'b0;
    end
    held_mods = make ? (held_mods | bits) : (held_mods & ~bits);
    ev.mask = held_mods;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input key_evt_t want, input key_evt_t got,
                               input logic [1:0] pad);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: exp named=%0d key=%0d char=%0d pressed=%0d mask=%02h text=%0d",
               $time, what, want.named, want.key_id, want.char_code, want.pressed,
               want.mask, want.text);
      $display("%0t %s: got named=%0d key=%0d char=%0d pressed=%0d mask=%02h text=%0d pad=%0d",
               $time, what, got.named, got.key_id, got.char_code, got.pressed,
               got.mask, got.text, pad);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    key_evt_t got;
    key_evt_t want;
    key_evt_t calc;
    logic     calc_hit;
    if (!rst_n) begin
      ext_pending = 1'b0;
      held_mods = 8'h00;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (out_tvalid && out_tready) begin
        got.named     = out_tuser;
        got.key_id    = out_tdata[4:0];
        got.char_code = out_tdata[11:5];
        got.pressed   = out_tdata[12];
        got.mask      = out_tdata[20:13];
        got.text      = out_tdata[21];
        if (pending_events.size() == 0) begin
          note_mismatch("unexpected result", NO_EVT, got, out_tdata[23:22]);
        end else begin
          want = pending_events.pop_front();
          if (got !== want || out_tdata[23:22] !== 2'b00)
            note_mismatch("wrong field", want, got, out_tdata[23:22]);
        end
      end
      if (in_tvalid && in_tready) begin
        calc_hit = decode_scan(in_tdata, calc);
        if (row_typed) begin
          if (row_hit)
            pending_events.push_back(row_ev);
        end else if (calc_hit) begin
          pending_events.push_back(calc);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else if (idle_en)
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    else
      out_tready <= 1'b1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // One request on the input side; returns on the edge where it is accepted.
  task automatic send_scan(input logic [7:0] b, input logic typed, input logic hit,
                           input key_evt_t ev);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    row_typed <= typed;
    row_hit   <= hit;
    row_ev    <= ev;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_random_key();
    int         pick;
    logic       make;
    logic       ext;
    logic [6:0] base;
    pick = $urandom_range(0, 99);
    make = 1'($urandom_range(0, 1));
    ext = 1'b0;
    if (pick < 15) begin
      // noise, broken prefixes included
      send_scan(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_EVT);
      return;
    end else if (pick < 25) begin
      base = PLAIN_MOD_CODES[2'($urandom_range(0, 3))];
    end else if (pick < 35) begin
      ext = 1'b1;
      base = EXT_MOD_CODES[2'($urandom_range(0, 3))];
    end else if (pick < 47) begin
      ext = 1'b1;
      base = NAV_CODES[4'($urandom_range(0, 9))];
    end else if (pick < 57) begin
      base = 7'($urandom_range(0, 11));
      base = (base < 10) ? 7'(BC_F1 + base) : ((base == 10) ? BC_F11 : BC_F12);
    end else begin
      base = 7'($urandom_range(0, 63));
    end
    if (ext)
      send_scan(SC_PREFIX, 1'b0, 1'b0, NO_EVT);
    send_scan({~make, base}, 1'b0, 1'b0, NO_EVT);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++)
      send_scan(DIRECTED_ROWS[i].scan, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].hit,
                DIRECTED_ROWS[i].ev);

    // hold off until the directed results have all drained
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0)
      @(posedge clk);

    bytes_sent = 0;
    while (bytes_sent < NUM_RANDOM) begin
      idle_en <= !(bytes_sent >= 200 && bytes_sent < 300);
      if (bytes_sent >= 400 && bytes_sent < 402) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
          @(posedge clk);
      end
      send_random_key();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
